FILE: hdl/mvbam_pkg.sv
// shared constants, types and state codes of the block average monitor
package mvbam_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int COUNT_BITS  = 10;
    localparam int SUM_BITS    = SAMPLE_BITS + COUNT_BITS;
    localparam int FRAC_BITS   = 8;
    localparam int DIV_BITS    = SUM_BITS + FRAC_BITS;
    localparam int GAIN_BITS   = 16;
    localparam int PROD_BITS   = DIV_BITS + GAIN_BITS;
    localparam int VOLT_BITS   = 9;
    localparam int TRACK_BITS  = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam int DIV_CNT_BITS  = $clog2(DIV_BITS);

    localparam int DIFF_BITS      = ((SAMPLE_BITS > VOLT_BITS) ? SAMPLE_BITS : VOLT_BITS)
                                    + FRAC_BITS;
    localparam int RECIP_BITS     = 25;
    localparam int RECIP_SHIFT    = 27;
    localparam int CORR_PROD_BITS = DIFF_BITS + RECIP_BITS;
    localparam int CORR_Q_BITS    = CORR_PROD_BITS - RECIP_SHIFT;

    localparam logic [COUNT_BITS-1:0] CORR_DIV_ABOVE = COUNT_BITS'(6);
    localparam logic [COUNT_BITS-1:0] CORR_DIV_BELOW = COUNT_BITS'(7);

    // floor(x / 6) and floor(x / 7) as multiply and shift, exact for x below 2^24
    localparam logic [RECIP_BITS-1:0] RECIP_SIX   = RECIP_BITS'(22369622);
    localparam logic [RECIP_BITS-1:0] RECIP_SEVEN = RECIP_BITS'(19173962);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_BLOCK_LENGTH = 3'd0,
        CFG_CONV_GAIN    = 3'd1,
        CFG_CAL_VOLTAGE  = 3'd2,
        CFG_OVER_LIMIT   = 3'd3,
        CFG_UNDER_LIMIT  = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG_GO,
        ST_AVG_WAIT,
        ST_CORR_GO,
        ST_CORR_WAIT,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic                  start;
        logic [DIV_BITS-1:0]   dividend;
        logic [COUNT_BITS-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic                busy;
        logic [DIV_BITS-1:0] quotient;
    } t_div_rsp;

endpackage

FILE: hdl/mvbam_in_if.sv
// sample channel: valid, ready, a paused flag and one converter sample
interface mvbam_in_if;
    import mvbam_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   paused;

    modport source (output valid, output sample, output paused, input ready);
    modport sink   (input valid, input sample, input paused, output ready);
endinterface

FILE: hdl/mvbam_out_if.sv
// result channel: valid, ready and one block result
interface mvbam_out_if;
    import mvbam_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [VOLT_BITS-1:0]  voltage;
    logic [TRACK_BITS-1:0] max_voltage;
    logic [TRACK_BITS-1:0] min_voltage;
    logic [TRACK_BITS-1:0] over_duration;
    logic [TRACK_BITS-1:0] under_duration;
    logic                  over_active;
    logic                  under_active;

    modport source (
        output valid, output voltage, output max_voltage, output min_voltage,
        output over_duration, output under_duration, output over_active,
        output under_active, input ready
    );
    modport sink (
        input valid, input voltage, input max_voltage, input min_voltage,
        input over_duration, input under_duration, input over_active,
        input under_active, output ready
    );
endinterface

FILE: hdl/mvbam_div.sv
// restoring divider, one quotient bit per cycle
module mvbam_div
    import mvbam_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam logic [DIV_CNT_BITS-1:0] LAST_STEP = DIV_CNT_BITS'(DIV_BITS - 1);

    logic                    r_busy;
    logic                    r_done;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic [COUNT_BITS-1:0]   r_den;
    logic [COUNT_BITS-1:0]   r_rem;
    logic [DIV_BITS-1:0]     r_quo;

    logic [COUNT_BITS:0]     s_rem_sh;
    logic [COUNT_BITS:0]     s_rem_sub;
    logic                    s_ge;

    assign s_rem_sh  = {r_rem, r_quo[DIV_BITS-1]};
    assign s_ge      = s_rem_sh >= {1'b0, r_den};
    assign s_rem_sub = s_rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_den <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_BITS-2:0], s_ge};
            r_rem <= s_ge ? s_rem_sub[COUNT_BITS-1:0] : s_rem_sh[COUNT_BITS-1:0];
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.busy     = r_busy;
    assign o_rsp.quotient = r_quo;

endmodule

FILE: hdl/mains_voltage_block_average_monitor_top.sv
// block average monitor: sample summing, divider sequencer, peak and episode tracking
//
//  channel   dir  handshake          payload
//  i_smp     in   valid / ready      sample, paused
//  o_res     out  valid / ready      voltage, max/min, over/under duration and active
//  i_cfg_*   in   write enable only  index, data
//
// a sample that does not end a block, or is paused, is taken while the sequencer stays idle
// a block-ending sample starts the sequencer: the divider forms the
// average, then the gain and the sixth or seventh correction take one multiply each
// reset is synchronous and clears the control, sum and tracking registers; no clearing pass
// the result sits in an output register; samples are taken while it waits,
// and only a block end stalls until it is free
module mains_voltage_block_average_monitor_top
    import mvbam_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    mvbam_in_if.sink                 i_smp,
    mvbam_out_if.source              o_res
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX  = {COUNT_BITS{1'b1}};
    localparam logic [VOLT_BITS-1:0]  VOLT_SAT = {VOLT_BITS{1'b1}};

    t_state r_state;
    t_state n_state;

    logic [COUNT_BITS-1:0] r_block_length;
    logic [GAIN_BITS-1:0]  r_gain;
    logic [VOLT_BITS-1:0]  r_cal;
    logic [VOLT_BITS-1:0]  r_over_lim;
    logic [VOLT_BITS-1:0]  r_under_lim;

    logic [SUM_BITS-1:0]   r_sum;
    logic [COUNT_BITS-1:0] r_count;
    logic [DIV_BITS-1:0]   r_v8;
    logic                  r_above;
    logic [DIFF_BITS-1:0]  r_diff;
    logic [TRACK_BITS-1:0] r_block_counter;
    logic [TRACK_BITS-1:0] r_max_seen;
    logic [TRACK_BITS-1:0] r_min_seen;
    logic [TRACK_BITS-1:0] r_over_time;
    logic [TRACK_BITS-1:0] r_under_time;
    logic                  r_over_flag;
    logic                  r_under_flag;
    logic                  r_out_valid;
    logic [VOLT_BITS-1:0]  r_voltage;

    t_div_req s_req;
    t_div_rsp s_rsp;

    logic                  s_take;
    logic                  s_ready;
    logic                  s_acc;
    logic [COUNT_BITS-1:0] s_n;
    logic [SUM_BITS-1:0]   s_sum_add;
    logic                  s_end;
    logic [PROD_BITS-1:0]  s_prod;
    logic [DIV_BITS-1:0]   s_c8;
    logic                  s_v_above;
    logic [RECIP_BITS-1:0]     s_recip;
    logic [CORR_PROD_BITS-1:0] s_corr_prod;
    logic [CORR_Q_BITS-1:0]    s_corr_q;
    logic                  s_fin_go;
    logic [DIV_BITS-FRAC_BITS-1:0] s_whole;
    logic [VOLT_BITS-1:0]  s_v;
    logic [TRACK_BITS-1:0] s_ac;
    logic [TRACK_BITS-1:0] s_bc1;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_length <= COUNT_BITS'(40);
            r_gain         <= GAIN_BITS'(5752);
            r_cal          <= VOLT_BITS'(215);
            r_over_lim     <= VOLT_BITS'(250);
            r_under_lim    <= VOLT_BITS'(190);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BLOCK_LENGTH: r_block_length <= i_cfg_data[COUNT_BITS-1:0];
                CFG_CONV_GAIN:    r_gain         <= i_cfg_data[GAIN_BITS-1:0];
                CFG_CAL_VOLTAGE:  r_cal          <= i_cfg_data[VOLT_BITS-1:0];
                CFG_OVER_LIMIT:   r_over_lim     <= i_cfg_data[VOLT_BITS-1:0];
                CFG_UNDER_LIMIT:  r_under_lim    <= i_cfg_data[VOLT_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign s_take      = i_smp.valid && s_ready;
    assign s_acc       = s_take && !i_smp.paused;
    assign s_n         = r_count + 1'b1;
    assign s_sum_add   = r_sum + SUM_BITS'(i_smp.sample);
    assign s_end       = (s_n >= r_block_length) || (s_n == CNT_MAX);
    assign s_prod      = s_rsp.quotient * r_gain;
    assign s_c8        = DIV_BITS'({r_cal, {FRAC_BITS{1'b0}}});
    assign s_v_above   = r_v8 > s_c8;
    assign s_recip     = r_above ? RECIP_SIX : RECIP_SEVEN;
    assign s_corr_prod = r_diff * s_recip;
    assign s_corr_q    = s_corr_prod[CORR_PROD_BITS-1:RECIP_SHIFT];
    assign s_fin_go    = !r_out_valid || o_res.ready;
    assign s_whole     = r_v8[DIV_BITS-1:FRAC_BITS];
    assign s_v         = (|s_whole[DIV_BITS-FRAC_BITS-1:VOLT_BITS]) ? VOLT_SAT
                                                                    : s_whole[VOLT_BITS-1:0];
    assign s_ac        = TRACK_BITS'(s_v);
    assign s_bc1       = r_block_counter + 1'b1;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (s_acc && s_end) n_state = ST_AVG_GO;
            ST_AVG_GO:    n_state = ST_AVG_WAIT;
            ST_AVG_WAIT:  if (s_rsp.done) n_state = ST_CORR_GO;
            ST_CORR_GO:   n_state = ST_CORR_WAIT;
            ST_CORR_WAIT: n_state = ST_FIN;
            ST_FIN:       if (s_fin_go) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready        = 1'b0;
        s_req.start    = 1'b0;
        s_req.dividend = {r_sum, {FRAC_BITS{1'b0}}};
        s_req.divisor  = r_count;
        unique case (r_state)
            ST_IDLE:   s_ready = 1'b1;
            ST_AVG_GO: s_req.start = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum           <= '0;
            r_count         <= '0;
            r_block_counter <= '0;
            r_max_seen      <= '0;
            r_min_seen      <= '1;
            r_over_time     <= '0;
            r_under_time    <= '0;
            r_over_flag     <= 1'b0;
            r_under_flag    <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_IDLE && s_acc) begin
                r_sum   <= s_sum_add;
                r_count <= s_n;
            end
            if (r_state == ST_FIN && s_fin_go) begin
                r_sum           <= '0;
                r_count         <= '0;
                r_out_valid     <= 1'b1;
                r_block_counter <= s_bc1;
                if (s_ac > r_max_seen) begin
                    r_max_seen <= s_ac;
                end
                if (s_ac < r_min_seen) begin
                    r_min_seen <= s_ac;
                end
                priority if (!r_over_flag && s_v > r_over_lim) begin
                    r_over_flag <= 1'b1;
                    r_over_time <= s_bc1;
                end else if (!r_under_flag && s_v < r_under_lim) begin
                    r_under_flag <= 1'b1;
                    r_under_time <= s_bc1;
                end else if (r_over_flag && s_v < r_over_lim) begin
                    r_over_time     <= TRACK_BITS'({s_bc1 - r_over_time, 1'b0});
                    r_over_flag     <= 1'b0;
                    r_block_counter <= '0;
                end else if (r_under_flag && s_v > r_under_lim) begin
                    r_under_time    <= TRACK_BITS'({s_bc1 - r_under_time, 1'b0});
                    r_under_flag    <= 1'b0;
                    r_block_counter <= '0;
                end else begin
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_AVG_WAIT && s_rsp.done) begin
            r_v8 <= s_prod[PROD_BITS-1:GAIN_BITS];
        end else if (r_state == ST_CORR_WAIT) begin
            r_v8 <= r_above ? (r_v8 - DIV_BITS'(s_corr_q)) : (r_v8 + DIV_BITS'(s_corr_q));
        end
        if (r_state == ST_CORR_GO) begin
            r_above <= s_v_above;
            r_diff  <= s_v_above ? DIFF_BITS'(r_v8 - s_c8) : DIFF_BITS'(s_c8 - r_v8);
        end
        if (r_state == ST_FIN && s_fin_go) begin
            r_voltage <= s_v;
        end
    end

    mvbam_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (s_req),
        .o_rsp   (s_rsp)
    );

    assign i_smp.ready          = s_ready;
    assign o_res.valid          = r_out_valid;
    assign o_res.voltage        = r_voltage;
    assign o_res.max_voltage    = r_max_seen;
    assign o_res.min_voltage    = r_min_seen;
    assign o_res.over_duration  = r_over_time;
    assign o_res.under_duration = r_under_time;
    assign o_res.over_active    = r_over_flag;
    assign o_res.under_active   = r_under_flag;

    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_rsp.done |-> (r_state == ST_AVG_WAIT || r_state == ST_CORR_WAIT))
        else $error("divider finished outside a wait state");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_FIN)
        else $error("result loaded outside block end");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_min_seen <= r_max_seen)
        else $error("minimum above maximum");

    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_req.start |-> !s_rsp.busy)
        else $error("divider restarted while busy");

endmodule
